// ===== rtl/mbad_pkg.sv =====
// package: shared types and constants for the main bus address decoder
`timescale 1ns / 1ps

package mbad_pkg;

    // target codes
    localparam logic [3:0] TGT_ROM    = 4'd0;
    localparam logic [3:0] TGT_TILE   = 4'd1;
    localparam logic [3:0] TGT_TEXT   = 4'd2;
    localparam logic [3:0] TGT_SPRITE = 4'd3;
    localparam logic [3:0] TGT_PAL    = 4'd4;
    localparam logic [3:0] TGT_PPI    = 4'd5;
    localparam logic [3:0] TGT_PORT0  = 4'd6;
    localparam logic [3:0] TGT_PORT1  = 4'd7;
    localparam logic [3:0] TGT_PORT2  = 4'd8;
    localparam logic [3:0] TGT_WRAM   = 4'd9;
    localparam logic [3:0] TGT_CONST  = 4'd10;

    // access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // configuration register indexes
    localparam logic REG_DIP_A = 1'b0;
    localparam logic REG_DIP_B = 1'b1;

    // configuration reset values
    localparam logic [7:0] DIP_A_RESET = 8'hFF;
    localparam logic [7:0] DIP_B_RESET = 8'hFC;

    // constant read values
    localparam logic [15:0] CONST_OPEN_BUS = 16'hFFFF;
    localparam logic [15:0] CONST_BYTE_FF  = 16'h00FF;

    // work ram word that fires the sound latch
    localparam logic [12:0] LATCH_WORD = 13'h038;

    // input word
    typedef struct packed {
        logic        cmd;
        logic [23:0] bus_address;
    } access_t;

    // result word
    typedef struct packed {
        logic [3:0]  target;
        logic [16:0] word_offset;
        logic [15:0] constant_data;
        logic        latch_strobe;
    } result_t;

    // dip switch settings
    typedef struct packed {
        logic [7:0] dip_a;
        logic [7:0] dip_b;
    } dip_cfg_t;

endpackage

// ===== rtl/mbad_cfg_regs.sv =====
// module: dip switch configuration registers
`timescale 1ns / 1ps

module mbad_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata,
    output mbad_pkg::dip_cfg_t  dip_cfg
);

    logic [7:0] dip_a_reg;
    logic [7:0] dip_b_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dip_a_reg <= mbad_pkg::DIP_A_RESET;
            dip_b_reg <= mbad_pkg::DIP_B_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                mbad_pkg::REG_DIP_A: dip_a_reg <= cfg_wdata;
                mbad_pkg::REG_DIP_B: dip_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign dip_cfg.dip_a = dip_a_reg;
    assign dip_cfg.dip_b = dip_b_reg;

endmodule

// ===== rtl/mbad_decode.sv =====
// module: combinational address map decode of one bus access
`timescale 1ns / 1ps

module mbad_decode (
    input  mbad_pkg::access_t   access,
    input  mbad_pkg::dip_cfg_t  dip_cfg,
    output mbad_pkg::result_t   result
);

    logic        wr;
    logic [23:0] a;
    logic [12:0] wram_off;

    assign wr       = (access.cmd == mbad_pkg::CMD_WRITE);
    assign a        = access.bus_address;
    assign wram_off = a[13:1];

    // region decode
    always_comb begin
        result.target        = mbad_pkg::TGT_CONST;
        result.word_offset   = '0;
        result.constant_data = wr ? 16'h0000 : mbad_pkg::CONST_OPEN_BUS;
        result.latch_strobe  = 1'b0;
        case (a[23:22])
            // program rom, writes ignored
            2'b00: begin
                if (!wr) begin
                    result.target        = mbad_pkg::TGT_ROM;
                    result.word_offset   = a[17:1];
                    result.constant_data = '0;
                end
            end
            // tile, text and sprite
            2'b01: begin
                if (a[18:16] == 3'b000) begin
                    result.target      = mbad_pkg::TGT_TILE;
                    result.word_offset = {3'b000, a[14:1]};
                end else if (a[18:16] == 3'b001) begin
                    result.target      = mbad_pkg::TGT_TEXT;
                    result.word_offset = {6'b000000, a[11:1]};
                end else if (a[18]) begin
                    result.target      = mbad_pkg::TGT_SPRITE;
                    result.word_offset = {7'b0000000, a[10:1]};
                end
                if (result.target != mbad_pkg::TGT_CONST) begin
                    result.constant_data = '0;
                end
            end
            // palette
            2'b10: begin
                if (a[19:18] == 2'b01) begin
                    result.target        = mbad_pkg::TGT_PAL;
                    result.word_offset   = {6'b000000, a[11:1]};
                    result.constant_data = '0;
                end
            end
            // tile, text, io area and work ram
            default: begin
                if (a[18:16] == 3'b000) begin
                    result.target        = mbad_pkg::TGT_TILE;
                    result.word_offset   = {3'b000, a[14:1]};
                    result.constant_data = '0;
                end else if (a[18:16] == 3'b001) begin
                    result.target        = mbad_pkg::TGT_TEXT;
                    result.word_offset   = {6'b000000, a[11:1]};
                    result.constant_data = '0;
                end else if (a[18:16] == 3'b111) begin
                    result.target        = mbad_pkg::TGT_WRAM;
                    result.word_offset   = {4'b0000, wram_off};
                    result.constant_data = '0;
                    result.latch_strobe  = wr && (wram_off == mbad_pkg::LATCH_WORD);
                end else if (a[18:17] == 2'b10) begin
                    // io area
                    if (a[13:12] == 2'b00) begin
                        result.target        = mbad_pkg::TGT_PPI;
                        result.word_offset   = {15'd0, a[2:1]};
                        result.constant_data = '0;
                    end else if (!wr) begin
                        case (a[13:12])
                            2'b01: begin
                                result.constant_data = '0;
                                case (a[2:1])
                                    2'b00: result.target = mbad_pkg::TGT_PORT0;
                                    2'b01: result.target = mbad_pkg::TGT_PORT1;
                                    2'b11: result.target = mbad_pkg::TGT_PORT2;
                                    default: result.constant_data = mbad_pkg::CONST_BYTE_FF;
                                endcase
                            end
                            2'b10: begin
                                result.constant_data = a[1] ? {8'h00, dip_cfg.dip_b}
                                                            : {8'h00, dip_cfg.dip_a};
                            end
                            default: result.constant_data = mbad_pkg::CONST_OPEN_BUS;
                        endcase
                    end
                end
            end
        endcase
    end

endmodule

// ===== rtl/main_bus_address_decoder_unit.sv =====
// top level: main bus address decoder with input and result registers
//
//  channel   direction  handshake          word
//  s_        in         s_valid / s_ready  mbad_pkg::access_t (cmd, bus_address)
//  m_        out        m_valid / m_ready  mbad_pkg::result_t (target .. latch_strobe)
//  cfg_      in         cfg_we             cfg_index, cfg_wdata (dip switches)
//
// an accepted word is held in the input register, decoded, then loaded into the result register
// one word a cycle sustained while m_ready stays high, with a single decode pass between the two registers
// a stalled m_ready holds the result; s_ready drops only when both registers are full
// and m_ready is low
// synchronous active-low reset empties both stages and loads the dip switch defaults
`timescale 1ns / 1ps

module main_bus_address_decoder_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mbad_pkg::access_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mbad_pkg::result_t   m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata
);

    logic               in_valid_reg;
    mbad_pkg::access_t  in_word_reg;
    logic               out_valid_reg;
    mbad_pkg::result_t  out_word_reg;
    mbad_pkg::dip_cfg_t dip_cfg;
    mbad_pkg::result_t  decoded;
    logic               out_load;

    mbad_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .dip_cfg   (dip_cfg)
    );

    mbad_decode u_decode (
        .access  (in_word_reg),
        .dip_cfg (dip_cfg),
        .result  (decoded)
    );

    // pipeline advance
    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_load && in_valid_reg) begin
            out_word_reg <= decoded;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

// ===== rtl/mbad_checker.sv =====
// checker: port-level properties of the main bus address decoder, with its bind
`timescale 1ns / 1ps

module mbad_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input mbad_pkg::result_t  m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // strobe only from work ram
    a_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.latch_strobe |-> m_data.target == mbad_pkg::TGT_WRAM)
        else $error("latch strobe outside work ram");

    // constant data only on constant target
    a_const: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.constant_data != 16'h0000
            |-> m_data.target == mbad_pkg::TGT_CONST)
        else $error("constant data on mapped target");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input never blocked while output side drains
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled with free output");

endmodule

bind main_bus_address_decoder_unit mbad_checker u_mbad_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/main_bus_address_decoder_unit_test.sv =====
// testbench: main bus address decoder unit, self-checking with random access words
`timescale 1ns / 1ps

module main_bus_address_decoder_unit_test;

    import mbad_pkg::*;

    // address map boundaries on the low 19 address bits
    localparam logic [18:0] TILE_LAST   = 19'h0FFFF;
    localparam logic [18:0] TEXT_LAST   = 19'h1FFFF;
    localparam logic [18:0] UPPER_FIRST = 19'h40000;
    localparam logic [18:0] IO_LAST     = 19'h5FFFF;
    localparam logic [18:0] WRAM_FIRST  = 19'h70000;

    // io area selects on address bits 13:12
    localparam logic [1:0] IO_PPI  = 2'd0;
    localparam logic [1:0] IO_PORT = 2'd1;
    localparam logic [1:0] IO_DIP  = 2'd2;

    localparam int PHASE_WORDS   = 235;
    localparam int HOLD_AT       = 600;
    localparam int HOLD_CYCLES   = 300;
    localparam int STEADY_FIRST  = 150;
    localparam int STEADY_LAST   = 450;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    access_t   s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    result_t   m_data;
    logic      cfg_we = 1'b0;
    logic      cfg_index = REG_DIP_A;
    logic [7:0] cfg_wdata = '0;

    // dip switch copies used for prediction
    logic [7:0] dip_a = DIP_A_RESET;
    logic [7:0] dip_b = DIP_B_RESET;

    access_t pending_accesses[$];
    result_t expected_results[$];
    int      words_sent = 0;
    int      results_seen = 0;
    int      error_count = 0;
    int      rx_hold_left = 0;
    bit      rx_hold_done = 1'b0;

    main_bus_address_decoder_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decode of the io area
    function automatic result_t decode_io(logic wr, logic [23:0] a);
        result_t r;
        r = '0;
        r.target = TGT_CONST;
        if (a[13:12] == IO_PPI) begin
            r.target = TGT_PPI;
            r.word_offset = 17'(a[2:1]);
        end else if (!wr) begin
            if (a[13:12] == IO_PORT) begin
                case (a[2:1])
                    2'd0: r.target = TGT_PORT0;
                    2'd1: r.target = TGT_PORT1;
                    2'd3: r.target = TGT_PORT2;
                    default: r.constant_data = CONST_BYTE_FF;
                endcase
            end else if (a[13:12] == IO_DIP) begin
                r.constant_data = {8'h00, a[1] ? dip_b : dip_a};
            end else begin
                r.constant_data = CONST_OPEN_BUS;
            end
        end
        return r;
    endfunction

    // expected result word of one access
    function automatic result_t decode_access(access_t acc);
        logic [23:0] a;
        logic [18:0] low;
        logic        wr;
        result_t     r;
        a = acc.bus_address;
        low = a[18:0];
        wr = (acc.cmd == CMD_WRITE);
        r = '0;
        r.target = TGT_CONST;
        // unmapped reads give open bus, ignored writes stay all zero
        if (!wr)
            r.constant_data = CONST_OPEN_BUS;
        case (a[23:22])
            2'b00: begin
                r.constant_data = '0;
                if (!wr) begin
                    r.target = TGT_ROM;
                    r.word_offset = a[17:1];
                end
            end
            2'b01: begin
                if (low <= TILE_LAST) begin
                    r = '0;
                    r.target = TGT_TILE;
                    r.word_offset = 17'(a[14:1]);
                end else if (low <= TEXT_LAST) begin
                    r = '0;
                    r.target = TGT_TEXT;
                    r.word_offset = 17'(a[11:1]);
                end else if (low >= UPPER_FIRST) begin
                    r = '0;
                    r.target = TGT_SPRITE;
                    r.word_offset = 17'(a[10:1]);
                end
            end
            2'b10: begin
                if (a[19:18] == 2'b01) begin
                    r = '0;
                    r.target = TGT_PAL;
                    r.word_offset = 17'(a[11:1]);
                end
            end
            default: begin
                if (low <= TILE_LAST) begin
                    r = '0;
                    r.target = TGT_TILE;
                    r.word_offset = 17'(a[14:1]);
                end else if (low <= TEXT_LAST) begin
                    r = '0;
                    r.target = TGT_TEXT;
                    r.word_offset = 17'(a[11:1]);
                end else if (low >= UPPER_FIRST && low <= IO_LAST) begin
                    r = decode_io(wr, a);
                end else if (low >= WRAM_FIRST) begin
                    r = '0;
                    r.target = TGT_WRAM;
                    r.word_offset = 17'(a[13:1]);
                    r.latch_strobe = wr && (a[13:1] == LATCH_WORD);
                end
            end
        endcase
        return r;
    endfunction

    // random access word, mostly aimed at mapped regions
    function automatic access_t random_access();
        access_t acc;
        logic [23:0] a;
        a = 24'($urandom);
        case ($urandom_range(0, 9))
            1: a[23:22] = 2'b00;
            2: a[23:22] = 2'b01;
            3: a[23:22] = 2'b10;
            4, 5, 6: a[23:22] = 2'b11;
            7, 8: begin
                a[23:22] = 2'b11;
                a[18:17] = 2'b10;
            end
            9: begin
                a[23:22] = 2'b11;
                a[18:16] = 3'b111;
                if ($urandom_range(0, 2) == 0)
                    a[13:1] = LATCH_WORD;
            end
            default: ;
        endcase
        acc.cmd = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
        acc.bus_address = a;
        return acc;
    endfunction

    // append to the pending access queue
    task automatic add_pending(access_t acc);
        pending_accesses.insert(pending_accesses.size(), acc);
    endtask

    // append to the expected result queue
    task automatic add_expected(result_t res);
        expected_results.insert(expected_results.size(), res);
    endtask

    task automatic queue_access(logic cmd, logic [23:0] addr);
        access_t acc;
        acc.cmd = cmd;
        acc.bus_address = addr;
        add_pending(acc);
    endtask

    task automatic report_mismatch(string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // dip switch write, only while the block is idle
    task automatic write_dip(logic idx, logic [7:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_DIP_A)
            dip_a = value;
        else
            dip_b = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // wait for every queued word to go in and every result to come out
    task automatic wait_idle();
        while (pending_accesses.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // driver: offers queued access words, predicts on acceptance
    always @(posedge aclk) begin
        bit tx_idle;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                add_expected(decode_access(s_data));
                words_sent++;
            end
            if (!s_valid || s_ready) begin
                tx_idle = !(words_sent >= STEADY_FIRST && words_sent < STEADY_LAST)
                          && ($urandom_range(0, 99) < 22);
                if (pending_accesses.size() != 0 && !tx_idle) begin
                    s_valid <= 1'b1;
                    s_data <= pending_accesses.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks result words, drives m_ready with random stalls and one long hold
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word %h with none expected", m_data));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.target !== want.target)
                        report_mismatch($sformatf("target %0d, expected %0d",
                                                  m_data.target, want.target));
                    if (m_data.word_offset !== want.word_offset)
                        report_mismatch($sformatf("word_offset %h, expected %h",
                                                  m_data.word_offset, want.word_offset));
                    if (m_data.constant_data !== want.constant_data)
                        report_mismatch($sformatf("constant_data %h, expected %h",
                                                  m_data.constant_data, want.constant_data));
                    if (m_data.latch_strobe !== want.latch_strobe)
                        report_mismatch($sformatf("latch_strobe %b, expected %b",
                                                  m_data.latch_strobe, want.latch_strobe));
                end
            end
            if (results_seen == HOLD_AT && !rx_hold_done) begin
                rx_hold_left = HOLD_CYCLES;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else if (results_seen >= STEADY_FIRST && results_seen < STEADY_LAST) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [7:0] dip_settings[5][2];
        dip_settings[0] = '{8'h00, 8'h00};
        dip_settings[1] = '{8'hFF, 8'hFF};
        dip_settings[2] = '{8'($urandom), 8'($urandom)};
        dip_settings[3] = '{8'h01, 8'h80};
        dip_settings[4] = '{8'($urandom), 8'($urandom)};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words with the reset dip values
        queue_access(CMD_READ,  24'h000000);
        queue_access(CMD_READ,  24'h3FFFFF);
        queue_access(CMD_WRITE, 24'h123456);
        queue_access(CMD_READ,  24'h400000);
        queue_access(CMD_READ,  24'h40FFFE);
        queue_access(CMD_READ,  24'h41FFFF);
        queue_access(CMD_READ,  24'h420000);
        queue_access(CMD_WRITE, 24'h420000);
        queue_access(CMD_READ,  24'h7FFFFF);
        queue_access(CMD_READ,  24'h800000);
        queue_access(CMD_WRITE, 24'h87FFFE);
        queue_access(CMD_READ,  24'hBFFFFF);
        queue_access(CMD_READ,  24'hC00000);
        queue_access(CMD_READ,  24'hC40006);
        queue_access(CMD_WRITE, 24'hC40002);
        queue_access(CMD_READ,  24'hC41000);
        queue_access(CMD_READ,  24'hC41003);
        queue_access(CMD_READ,  24'hC41004);
        queue_access(CMD_READ,  24'hC41007);
        queue_access(CMD_WRITE, 24'hC41000);
        queue_access(CMD_READ,  24'hC42000);
        queue_access(CMD_READ,  24'hC42002);
        queue_access(CMD_READ,  24'hC43000);
        queue_access(CMD_WRITE, 24'hC70070);
        queue_access(CMD_READ,  24'hC70070);
        queue_access(CMD_READ,  24'hC60000);
        queue_access(CMD_WRITE, 24'hFFFFFF);
        wait_idle();

        // random phases, each under its own dip switch setting
        for (int p = 0; p < 5; p++) begin
            write_dip(REG_DIP_A, dip_settings[p][0]);
            write_dip(REG_DIP_B, dip_settings[p][1]);
            for (int i = 0; i < PHASE_WORDS; i++)
                add_pending(random_access());
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_results.size()));
        if (error_count == 0)
            $display("main_bus_address_decoder_unit_test: done, clean");
        else
            $display("main_bus_address_decoder_unit_test: done, errors");
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("main_bus_address_decoder_unit_test: done, errors");
        $finish;
    end

endmodule
